FILE: hw/rtl/slpcrx_pkg.sv
// Shared types and constants for the sync/length packet checksum receiver.
`default_nettype none

package slpcrx_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 9;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h75;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h65;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_end;
        logic               checksum_ok;
        logic [BYTE_W-1:0]  frame_desc_set;
        logic [BYTE_W-1:0]  frame_length;
    } frame_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/slpcrx_if.sv
// Channel interfaces: received bytes, frame results and register writes.
`default_nettype none

interface slpcrx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slpcrx_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       checksum_ok;
    logic [7:0] frame_desc_set;
    logic [7:0] frame_length;

    modport source (
        output valid, output frame_byte, output byte_index, output frame_end,
        output checksum_ok, output frame_desc_set, output frame_length,
        input ready
    );
    modport sink (
        input valid, input frame_byte, input byte_index, input frame_end,
        input checksum_ok, input frame_desc_set, input frame_length,
        output ready
    );
endinterface

interface slpcrx_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sync_length_packet_checksum_rx.sv
// Top level of the sync/length packet checksum receiver.
`default_nettype none

// Receives one serial byte per transfer, one byte per clock sustained. The
// block hunts for the two configured sync bytes, then passes out the
// descriptor byte (index 0), the length byte (index 1) and each payload byte
// (index 2 onward), swallows the first checksum byte and ends the frame with
// a result that has frame_end set and checksum_ok telling whether both 8-bit
// Fletcher sums (over sync, descriptor, length and payload) matched. Each
// byte is processed in the cycle it is accepted and its result lands in a
// single output register; the input is ready whenever that register is empty
// or being drained, so a result waiting downstream stalls input only while
// the output side holds ready low. Sync bytes may be rewritten through the
// configuration channel, which is always ready; writes to unknown indexes
// are ignored.
module sync_length_packet_checksum_rx (
    input wire logic   clk,
    input wire logic   rst_n,
    slpcrx_rx_if.sink  rx,
    slpcrx_res_if.source res,
    slpcrx_cfg_if.sink cfg
);
    import slpcrx_pkg::*;

    logic              take;
    logic              free;
    logic              dec_valid;
    frame_res_t        dec_res;
    frame_res_t        out_res;
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;

    assign cfg.ready = 1'b1;
    assign rx.ready  = free;
    assign take      = rx.valid && free;

    slpcrx_sync_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg.valid),
        .wr_index    (cfg.index),
        .wr_data     (cfg.data),
        .sync_first  (sync_first),
        .sync_second (sync_second)
    );

    slpcrx_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx.rx_byte),
        .sync_first  (sync_first),
        .sync_second (sync_second),
        .res_valid   (dec_valid),
        .res         (dec_res)
    );

    slpcrx_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .load_valid (dec_valid),
        .load_res   (dec_res),
        .free       (free),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_res    (out_res)
    );

    assign res.frame_byte     = out_res.frame_byte;
    assign res.byte_index     = out_res.byte_index;
    assign res.frame_end      = out_res.frame_end;
    assign res.checksum_ok    = out_res.checksum_ok;
    assign res.frame_desc_set = out_res.frame_desc_set;
    assign res.frame_length   = out_res.frame_length;

endmodule

`default_nettype wire

FILE: hw/rtl/slpcrx_sync_cfg.sv
// Sync byte configuration registers.
`default_nettype none

module slpcrx_sync_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [slpcrx_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [slpcrx_pkg::BYTE_W-1:0]    wr_data,
    output logic      [slpcrx_pkg::BYTE_W-1:0]    sync_first,
    output logic      [slpcrx_pkg::BYTE_W-1:0]    sync_second
);
    import slpcrx_pkg::*;

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else if (wr_en)
        begin
            // drop writes to unknown indexes
            case (wr_index)
                REG_SYNC_FIRST:  sync_first_reg  <= wr_data;
                REG_SYNC_SECOND: sync_second_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign sync_first  = sync_first_reg;
    assign sync_second = sync_second_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/slpcrx_deframer.sv
// Frame state machine with running Fletcher sums; results for descriptor, length, payload bytes and frame end.
`default_nettype none

module slpcrx_deframer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      take,
    input  wire logic [slpcrx_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [slpcrx_pkg::BYTE_W-1:0] sync_first,
    input  wire logic [slpcrx_pkg::BYTE_W-1:0] sync_second,
    output logic                           res_valid,
    output slpcrx_pkg::frame_res_t         res
);
    import slpcrx_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_DESC,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK1,
        PH_CHECK2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0] desc_reg, desc_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] check_reg, check_next;

    logic [BYTE_W-1:0] acc_a;
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] pay_pos;

    assign acc_a    = sum_a_reg + rx_byte;
    assign sync_a   = sync_first + rx_byte;
    assign left_dec = left_reg - 8'd1;
    assign pay_pos  = len_reg - left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        desc_next  = desc_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        check_next = check_reg;
        res_valid  = 1'b0;
        res.frame_byte  = rx_byte;
        res.byte_index  = '0;
        res.frame_end   = 1'b0;
        res.checksum_ok = 1'b0;
        case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == sync_first)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (rx_byte == sync_second)
                begin
                    // sums restart over both sync bytes: a = s1 + s2, b = s1 + a
                    sum_a_next = sync_a;
                    sum_b_next = sync_first + sync_a;
                    desc_next  = '0;
                    len_next   = '0;
                    left_next  = '0;
                    phase_next = PH_DESC;
                end
                else if (rx_byte != sync_first)
                    phase_next = PH_HUNT1;
            end
            PH_DESC:
            begin
                sum_a_next = acc_a;
                sum_b_next = sum_b_reg + acc_a;
                desc_next  = rx_byte;
                phase_next = PH_LEN;
                res_valid  = 1'b1;
            end
            PH_LEN:
            begin
                sum_a_next = acc_a;
                sum_b_next = sum_b_reg + acc_a;
                len_next   = rx_byte;
                left_next  = rx_byte;
                phase_next = (rx_byte == '0) ? PH_CHECK1 : PH_PAYLOAD;
                res_valid  = 1'b1;
                res.byte_index = INDEX_W'(1);
            end
            PH_PAYLOAD:
            begin
                sum_a_next = acc_a;
                sum_b_next = sum_b_reg + acc_a;
                left_next  = left_dec;
                if (left_dec == '0)
                    phase_next = PH_CHECK1;
                res_valid  = 1'b1;
                res.byte_index = {1'b0, pay_pos} + INDEX_W'(2);
            end
            PH_CHECK1:
            begin
                check_next = rx_byte;
                phase_next = PH_CHECK2;
            end
            PH_CHECK2:
            begin
                phase_next = PH_HUNT1;
                res_valid  = 1'b1;
                res.frame_byte  = '0;
                res.frame_end   = 1'b1;
                res.checksum_ok = (check_reg == sum_a_reg) && (rx_byte == sum_b_reg);
            end
            default:
                phase_next = PH_HUNT1;
        endcase
        // descriptor and length reflect the holds after this byte
        res.frame_desc_set = desc_next;
        res.frame_length   = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            desc_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            check_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            desc_reg  <= desc_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            check_reg <= check_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/slpcrx_out_stage.sv
// Result register between the deframer and the output channel.
`default_nettype none

module slpcrx_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic                   load_valid,
    input  wire slpcrx_pkg::frame_res_t load_res,
    output logic                        free,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output slpcrx_pkg::frame_res_t      out_res
);
    import slpcrx_pkg::*;

    logic       valid_reg, valid_next;
    frame_res_t res_reg;

    // take a new transfer when empty or when the held one leaves this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = load_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            res_reg <= load_res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the sync/length packet checksum receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slpcrx_pkg::*;

    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_DESC,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_CHECK_A,
        TAKE_CHECK_B
    } deframe_phase_e;

    localparam int GAP_MAX       = 3;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SETTLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS   = 180;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 400_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;

    slpcrx_rx_if  rx_ch ();
    slpcrx_res_if res_ch ();
    slpcrx_cfg_if cfg_ch ();

    sync_length_packet_checksum_rx uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Predictor state: sync settings as last written, and the deframer itself
    logic [7:0]     sync_a_cfg = SYNC_FIRST_RESET;
    logic [7:0]     sync_b_cfg = SYNC_SECOND_RESET;
    deframe_phase_e dphase     = SEEK_FIRST;
    logic [7:0]     fl_a       = '0;
    logic [7:0]     fl_b       = '0;
    logic [7:0]     desc_q     = '0;
    logic [7:0]     len_q      = '0;
    logic [7:0]     left_q     = '0;
    logic [7:0]     check_a_q  = '0;

    frame_res_t expected_frames[$];
    logic [7:0] rx_pending[$];

    int mismatches      = 0;
    int results_checked = 0;
    int ends_good       = 0;
    int ends_bad        = 0;
    int bytes_accepted  = 0;
    int stim_items      = 0;
    int frames_built    = 0;

    int rx_gap   = 0;
    int rx_run   = 0;
    bit rx_calm  = 1'b0;
    int res_hold = 0;
    int res_run  = 0;
    bit res_calm = 1'b0;

    function automatic void fold_fletcher(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    function automatic void deframe_predict(input logic [7:0] b);
        frame_res_t r;
        logic       has_res;
        logic [7:0] pos;
        r = '0;
        has_res = 1'b0;
        case (dphase)
            SEEK_FIRST:
            begin
                if (b == sync_a_cfg)
                    dphase = SEEK_SECOND;
            end
            SEEK_SECOND:
            begin
                if (b == sync_b_cfg)
                begin
                    fl_a = '0;
                    fl_b = '0;
                    fold_fletcher(sync_a_cfg);
                    fold_fletcher(b);
                    desc_q = '0;
                    len_q  = '0;
                    left_q = '0;
                    dphase = TAKE_DESC;
                end
                else if (b != sync_a_cfg)
                begin
                    dphase = SEEK_FIRST;
                end
            end
            TAKE_DESC:
            begin
                fold_fletcher(b);
                desc_q = b;
                dphase = TAKE_LEN;
                has_res = 1'b1;
                r.frame_byte = b;
                r.byte_index = 9'd0;
            end
            TAKE_LEN:
            begin
                fold_fletcher(b);
                len_q  = b;
                left_q = b;
                dphase = (b == 8'd0) ? TAKE_CHECK_A : TAKE_PAYLOAD;
                has_res = 1'b1;
                r.frame_byte = b;
                r.byte_index = 9'd1;
            end
            TAKE_PAYLOAD:
            begin
                fold_fletcher(b);
                pos = len_q - left_q;
                left_q = left_q - 8'd1;
                if (left_q == 8'd0)
                    dphase = TAKE_CHECK_A;
                has_res = 1'b1;
                r.frame_byte = b;
                r.byte_index = 9'd2 + {1'b0, pos};
            end
            TAKE_CHECK_A:
            begin
                check_a_q = b;
                dphase = TAKE_CHECK_B;
            end
            TAKE_CHECK_B:
            begin
                has_res = 1'b1;
                r.frame_end = 1'b1;
                r.checksum_ok = (check_a_q == fl_a) && (b == fl_b);
                dphase = SEEK_FIRST;
            end
            default:
            begin
                dphase = SEEK_FIRST;
            end
        endcase
        if (has_res)
        begin
            r.frame_desc_set = desc_q;
            r.frame_length = len_q;
            expected_frames = {expected_frames, r};
        end
    endfunction

    // Random idle gap per transfer, bounded by GAP_MAX, with occasional stretches of none
    function automatic int draw_gap(inout int run, inout bit calm);
        if (run <= 0)
        begin
            calm = ~calm;
            run = $urandom_range(8, 40);
        end
        run--;
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic string frame_text(input frame_res_t r);
        return $sformatf("byte=%02h idx=%0d end=%0b ok=%0b desc=%02h len=%02h",
                         r.frame_byte, r.byte_index, r.frame_end, r.checksum_ok,
                         r.frame_desc_set, r.frame_length);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= '0;
            rx_gap <= 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_predict(rx_ch.rx_byte);
                bytes_accepted++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (rx_gap > 0)
                begin
                    rx_ch.valid <= 1'b0;
                    rx_gap <= rx_gap - 1;
                end
                else if (rx_pending.size() > 0)
                begin
                    rx_ch.valid <= 1'b1;
                    rx_ch.rx_byte <= rx_pending.pop_front();
                    rx_gap <= draw_gap(rx_run, rx_calm);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_res_t got;
        frame_res_t want;
        int         hold_n;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            res_hold <= 0;
        end
        else
        begin
            hold_n = res_hold;
            if (res_ch.valid && res_ch.ready)
            begin
                got.frame_byte     = res_ch.frame_byte;
                got.byte_index     = res_ch.byte_index;
                got.frame_end      = res_ch.frame_end;
                got.checksum_ok    = res_ch.checksum_ok;
                got.frame_desc_set = res_ch.frame_desc_set;
                got.frame_length   = res_ch.frame_length;
                results_checked++;
                if (got.frame_end === 1'b1)
                begin
                    if (got.checksum_ok === 1'b1)
                        ends_good++;
                    else
                        ends_bad++;
                end
                if (expected_frames.size() == 0)
                begin
                    note_mismatch({"result with nothing expected: ", frame_text(got)});
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.frame_byte !== want.frame_byte
                        || got.byte_index !== want.byte_index
                        || got.frame_end !== want.frame_end
                        || got.checksum_ok !== want.checksum_ok
                        || got.frame_desc_set !== want.frame_desc_set
                        || got.frame_length !== want.frame_length)
                        note_mismatch({"expected ", frame_text(want),
                                       " got ", frame_text(got)});
                end
                hold_n = draw_gap(res_run, res_calm);
            end
            else if (hold_n > 0)
            begin
                hold_n--;
            end
            res_ch.ready <= (hold_n == 0);
            res_hold <= hold_n;
        end
    end

    // Build one frame under the current sync setting; keep < 0 queues all of it,
    // otherwise only its first keep bytes
    task automatic queue_frame(input logic [7:0] desc, input logic [7:0] len,
                               input bit bad_sum, input int keep);
        logic [7:0] bytes[$];
        logic [7:0] a;
        logic [7:0] b;
        a = '0;
        b = '0;
        bytes = '{sync_a_cfg, sync_b_cfg, desc, len};
        for (int i = 0; i < len; i++)
            bytes = {bytes, 8'($urandom_range(0, 255))};
        foreach (bytes[i])
        begin
            a = a + bytes[i];
            b = b + a;
        end
        if (bad_sum)
        begin
            if ($urandom_range(0, 1) == 0)
                a = a ^ 8'($urandom_range(1, 255));
            else
                b = b ^ 8'($urandom_range(1, 255));
        end
        bytes = {bytes, a, b};
        while (keep >= 0 && bytes.size() > keep)
            bytes.delete(bytes.size() - 1);
        rx_pending = {rx_pending, bytes};
        stim_items += bytes.size();
        frames_built++;
    endtask

    task automatic run_random(input int budget);
        int         start;
        int         pick;
        logic [7:0] len;
        logic [7:0] x;
        start = stim_items;
        while (stim_items - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                len = 8'($urandom_range(13, 255));
            else
                len = 8'($urandom_range(0, 12));
            if (pick < 6)
            begin
                queue_frame(8'($urandom_range(0, 255)), len, 1'b0, -1);
            end
            else if (pick < 8)
            begin
                queue_frame(8'($urandom_range(0, 255)), len, 1'b1, -1);
            end
            else if (pick == 8)
            begin
                // line noise; mostly ignored while hunting
                repeat ($urandom_range(1, 4))
                begin
                    rx_pending = {rx_pending, 8'($urandom_range(0, 255))};
                    stim_items++;
                end
            end
            else
            begin
                // broken sync: first byte, maybe repeated, then a stray byte
                rx_pending = {rx_pending, sync_a_cfg};
                stim_items++;
                if ($urandom_range(0, 1) == 1)
                begin
                    rx_pending = {rx_pending, sync_a_cfg};
                    stim_items++;
                end
                do
                    x = 8'($urandom_range(0, 255));
                while (x == sync_a_cfg || x == sync_b_cfg);
                rx_pending = {rx_pending, x};
                stim_items++;
            end
        end
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        while (rx_pending.size() != 0 || rx_ch.valid)
            @(negedge clk);
        while (expected_frames.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_frames.size() != 0)
        begin
            note_mismatch($sformatf("%0d results never arrived, oldest %s",
                                    expected_frames.size(), frame_text(expected_frames[0])));
            expected_frames.delete();
        end
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  sync_a_cfg = val;
            REG_SYNC_SECOND: sync_b_cfg = val;
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        logic [7:0] sync_plan [5][2];
        sync_plan = '{'{8'h00, 8'hFF}, '{8'hFF, 8'h00}, '{8'hA5, 8'hA5},
                      '{8'h00, 8'h00}, '{SYNC_FIRST_RESET, SYNC_SECOND_RESET}};
        sync_plan[3][0] = 8'($urandom_range(0, 255));
        sync_plan[3][1] = 8'($urandom_range(0, 255));

        rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_SYNC_FIRST;
        cfg_ch.data <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: hunting noise, broken sync, repeated first sync byte,
        // zero length, bad checksum, short good frame
        rx_pending = {rx_pending, 8'h00, 8'hFF, sync_a_cfg, 8'h3C, sync_a_cfg, sync_a_cfg};
        stim_items += 6;
        queue_frame(8'h00, 8'd0, 1'b0, -1);
        queue_frame(8'hFF, 8'd2, 1'b1, -1);
        queue_frame(8'h5A, 8'd1, 1'b0, -1);
        wait_idle();

        // longest frame reaches the top payload index
        queue_frame(8'($urandom_range(0, 255)), 8'd255, 1'b0, -1);
        run_random(PHASE_ITEMS);

        for (int p = 0; p < 5; p++)
        begin
            // leave the deframer mid-frame or waiting on the second sync byte
            if (p % 2 == 0)
                queue_frame(8'($urandom_range(0, 255)), 8'd3, 1'b0, 5);
            else
            begin
                rx_pending = {rx_pending, sync_a_cfg};
                stim_items++;
            end
            wait_idle();
            write_reg(REG_SYNC_FIRST, sync_plan[p][0]);
            write_reg(REG_SYNC_SECOND, sync_plan[p][1]);
            if (p == 3)
            begin
                write_reg(REG_UNMAPPED, 8'($urandom_range(0, 255)));
                write_reg(REG_TOP_INDEX, 8'($urandom_range(0, 255)));
            end
            @(negedge clk);
            run_random(PHASE_ITEMS);
        end
        wait_idle();

        $display("run covered %0d bytes in %0d frames under 6 sync settings", bytes_accepted,
                 frames_built);
        $display("checked %0d results: %0d frame ends good, %0d bad", results_checked,
                 ends_good, ends_bad);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout after %0d bytes, %0d results", bytes_accepted, results_checked);
        $display("tb: failure");
        $finish;
    end

endmodule
